/* rtl/core/cda_pkg.sv */
// Package for the cosine distance accumulator: widths, constants, control types.
// No dependencies.
`timescale 1ns / 1ps
package cda_pkg;
  localparam int ElemBits  = 16;
  localparam int MaxElems  = 4096;
  localparam int CountBits = $clog2(MaxElems + 1);
  localparam int DotBits   = 2 * ElemBits + CountBits - 1;
  localparam int NormBits  = 2 * ElemBits + CountBits - 2;
  localparam int ProdBits  = 2 * NormBits;
  localparam int RootBits  = NormBits;
  localparam int QuoBits   = 15;
  localparam int DistBits  = 16;
  localparam logic [DistBits-1:0] OneQ14 = DistBits'(16384);

  typedef enum logic [2:0] {
    ST_ACCUM, ST_MUL, ST_SQRT, ST_DIV, ST_OUT
  } cda_state_t;

  typedef struct packed {
    logic accum;
    logic clear;
    logic mul_step;
    logic sqrt_init;
    logic sqrt_step;
    logic div_init;
    logic div_step;
    logic load_out;
  } cda_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic sqrt_done;
    logic div_done;
  } cda_status_t;
endpackage

/* rtl/core/cosine_distance_accumulator_core.sv */
// Top level of the cosine distance accumulator: controller plus datapath.
// Depends on cda_pkg, cda_ctrl, cda_datapath.
//
// Input channel (in_valid/in_ready) takes one pair of Q1.15 elements per beat,
// one beat per cycle while accumulating. The beat with last_element high closes
// the vectors; in_ready then drops while the distance is computed by a
// shift-add multiply, a bitwise square root and a divide, each an iterative
// unit, and the result is then loaded into the output register.
// The result beat (out_valid/out_ready) carries distance (Q2.14), zero_norm and
// too_long; it sits in an output register, so the next vector is accepted while
// it waits. A second result waits in the load cycle for the first to be taken,
// which holds in_ready low. Pairs past MaxElems are dropped and flagged.
// Reset clears all sums, the overflow flag and the pending result; no clearing pass.
`timescale 1ns / 1ps
module cosine_distance_accumulator_core
  import cda_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [ElemBits-1:0] element_a,
  input  logic signed [ElemBits-1:0] element_b,
  input  logic                       last_element,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [DistBits-1:0]        distance,
  output logic                       zero_norm,
  output logic                       too_long
);
  cda_cmd_t    cmd;
  cda_status_t status;

  cda_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_last(last_element), .out_valid(out_valid), .out_ready(out_ready),
    .cmd(cmd), .status(status)
  );

  cda_datapath u_dp (
    .clk(clk), .rst(rst), .element_a(element_a), .element_b(element_b),
    .cmd(cmd), .status(status), .distance(distance),
    .zero_norm(zero_norm), .too_long(too_long)
  );
endmodule

/* rtl/core/cda_ctrl.sv */
// Controller for the cosine distance accumulator: sequences accumulate,
// multiply, square root and divide. Depends on cda_pkg.
`timescale 1ns / 1ps
module cda_ctrl
  import cda_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output cda_cmd_t    cmd,
  input  cda_status_t status
);
  cda_state_t state, state_next;
  logic out_full, out_full_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCUM;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      out_full <= out_full_next;
    end
  end

  assign out_valid = out_full;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_full_next = out_full && !out_ready;
    case (state)
      ST_ACCUM: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accum = 1'b1;
          if (in_last) state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (status.mul_done) begin
          cmd.sqrt_init = 1'b1;
          state_next = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (status.sqrt_done) begin
          cmd.div_init = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_full || out_ready) begin
          cmd.load_out = 1'b1;
          cmd.clear = 1'b1;
          out_full_next = 1'b1;
          state_next = ST_ACCUM;
        end
      end
      default: state_next = ST_ACCUM;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_ready_only_accum: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == ST_ACCUM) else $error("ready outside accumulate");
  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid) else $error("load without valid");
  a_last_leaves: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> state == ST_MUL) else $error("last not seen");
`endif
endmodule

/* rtl/core/cda_datapath.sv */
// Datapath: sums, shift-add product, bitwise square root, restoring divide.
// Depends on cda_pkg.
`timescale 1ns / 1ps
module cda_datapath
  import cda_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic signed [ElemBits-1:0] element_a,
  input  logic signed [ElemBits-1:0] element_b,
  input  cda_cmd_t                   cmd,
  output cda_status_t                status,
  output logic [DistBits-1:0]        distance,
  output logic                       zero_norm,
  output logic                       too_long
);
  localparam int MulCntBits = $clog2(NormBits + 1);
  localparam int SqCntBits  = $clog2(RootBits + 1);

  logic signed [DotBits-1:0] dot_sum;
  logic [NormBits-1:0] norm_a_sum, norm_b_sum;
  logic [CountBits-1:0] pair_count;
  logic overflow_seen;

  logic signed [2*ElemBits-1:0] pab, paa, pbb;
  assign pab = element_a * element_b;
  assign paa = element_a * element_a;
  assign pbb = element_b * element_b;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      dot_sum <= '0;
      norm_a_sum <= '0;
      norm_b_sum <= '0;
      pair_count <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.accum) begin
      if (pair_count >= CountBits'(MaxElems)) begin
        overflow_seen <= 1'b1;
      end else begin
        dot_sum <= dot_sum + DotBits'(pab);
        norm_a_sum <= norm_a_sum + NormBits'(paa);
        norm_b_sum <= norm_b_sum + NormBits'(pbb);
        pair_count <= pair_count + 1'b1;
      end
    end
  end

  // product P = na * nb, one multiplier bit a cycle
  logic [ProdBits-1:0] prod, mcand;
  logic [NormBits-1:0] mplier;
  logic [MulCntBits-1:0] mcnt;
  logic mul_busy;
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
      mcnt <= '0;
    end else if (cmd.mul_step) begin
      if (!mul_busy) begin
        mul_busy <= 1'b1;
        prod <= '0;
        mcand <= ProdBits'(norm_a_sum);
        mplier <= norm_b_sum;
        mcnt <= '0;
      end else if (mcnt != MulCntBits'(NormBits)) begin
        if (mplier[0]) prod <= prod + mcand;
        mcand <= mcand << 1;
        mplier <= mplier >> 1;
        mcnt <= mcnt + 1'b1;
      end else begin
        mul_busy <= 1'b0;
      end
    end
  end
  assign status.mul_done = mul_busy && (mcnt == MulCntBits'(NormBits));

  // restoring square root, two radicand bits per cycle
  logic [ProdBits-1:0] rad;
  logic [RootBits+1:0] rem;
  logic [RootBits-1:0] root;
  logic [SqCntBits-1:0] scnt;
  logic [RootBits+1:0] trial, rem_sh;
  assign rem_sh = {rem[RootBits-1:0], rad[ProdBits-1 -: 2]};
  assign trial = {root, 2'b01};
  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      rad <= prod;
      rem <= '0;
      root <= '0;
      scnt <= '0;
    end else if (cmd.sqrt_step && scnt != SqCntBits'(RootBits)) begin
      rad <= rad << 2;
      if (rem_sh >= trial) begin
        rem <= rem_sh - trial;
        root <= {root[RootBits-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        root <= {root[RootBits-2:0], 1'b0};
      end
      scnt <= scnt + 1'b1;
    end
  end
  assign status.sqrt_done = (scnt == SqCntBits'(RootBits));

  // |dot| * 2^15 / s, one quotient bit a cycle
  logic [DotBits-1:0] mag;
  assign mag = dot_sum[DotBits-1] ? DotBits'(-dot_sum) : DotBits'(dot_sum);
  logic [RootBits:0] r;
  logic [QuoBits-1:0] t;
  logic [4:0] dcnt;
  logic big, neg;
  logic [RootBits:0] r2;
  assign r2 = r << 1;
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      r <= (RootBits+1)'(mag);
      t <= '0;
      dcnt <= '0;
      neg <= dot_sum[DotBits-1];
      big <= ((RootBits+1)'(mag) >= {1'b0, root});
    end else if (cmd.div_step && dcnt != 5'(QuoBits)) begin
      if (r2 >= {1'b0, root}) begin
        r <= r2 - {1'b0, root};
        t <= {t[QuoBits-2:0], 1'b1};
      end else begin
        r <= r2;
        t <= {t[QuoBits-2:0], 1'b0};
      end
      dcnt <= dcnt + 1'b1;
    end
  end
  assign status.div_done = (dcnt == 5'(QuoBits));

  logic [DistBits-1:0] q;
  logic zn;
  assign q = big ? OneQ14 : DistBits'(({1'b0, t} + 1'b1) >> 1);
  assign zn = (norm_a_sum == '0) || (norm_b_sum == '0);
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      zero_norm <= zn;
      too_long <= overflow_seen;
      distance <= zn ? '0 : (neg ? OneQ14 + q : OneQ14 - q);
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    pair_count <= CountBits'(MaxElems)) else $error("count past limit");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> pair_count == '0 && !overflow_seen) else $error("sums not cleared");
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.load_out) |-> distance <= 2 * OneQ14) else $error("distance range");
`endif
endmodule
